// ----- hdl/srws_pkg.sv -----
package srws_pkg;

	localparam int SEQ_BITS     = 32;
	localparam int WORD_BITS    = 64;
	localparam int LEN_BITS     = 11;
	localparam int FLAG_BITS    = 8;
	localparam int WS_BITS      = 7;
	localparam int SLOTS        = 64;
	localparam int SLOT_BITS    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_BITS     = $clog2(SEQ_BITS + 1);
	localparam int CFG_IDX_BITS = 8;

	localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(SLOTS);

	localparam logic [CFG_IDX_BITS-1:0] REG_START_SEQ   = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = CFG_IDX_BITS'(1);

	typedef enum logic [1:0] {
		MODE_DATA    = 2'd0,
		MODE_ACK     = 2'd1,
		MODE_SREJ    = 2'd2,
		MODE_TIMEOUT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_IGNORED   = 3'd1,
		ST_FULL      = 3'd2,
		ST_ALL_ACKED = 3'd3,
		ST_BEYOND    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_SREJ    = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_EOF     = 2'd3
	} kind_t;

	typedef struct packed {
		mode_t                        mode;
		logic                         frame_ok;
		logic signed [SEQ_BITS-1:0]   seq_in;
		logic        [WORD_BITS-1:0]  data_word;
		logic        [LEN_BITS-1:0]   data_len;
		logic        [FLAG_BITS-1:0]  data_flag;
		logic                         file_done;
	} item_t;

	typedef struct packed {
		status_t                      status;
		logic                         send_valid;
		kind_t                        send_kind;
		logic signed [SEQ_BITS-1:0]   send_seq;
		logic        [WORD_BITS-1:0]  send_word;
		logic        [LEN_BITS-1:0]   send_len;
		logic        [FLAG_BITS-1:0]  send_flag;
		logic                         window_open;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_MOD,
		S_READ,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic read;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
	} stat_t;

endpackage

// ----- hdl/srws_mod.sv -----
module srws_mod import srws_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SEQ_BITS-1:0] value,
	input  logic        [WS_BITS-1:0]  divisor,
	output logic                       done,
	output logic        [SLOT_BITS-1:0] slot
);

	logic [CNT_BITS-1:0] cnt_q;
	logic [SEQ_BITS-1:0] dvd_q;
	logic [WS_BITS-1:0]  rem_q;
	logic [WS_BITS-1:0]  div_q;
	logic                neg_q;
	logic [WS_BITS-1:0]  trial;
	logic [WS_BITS-1:0]  fixed;

	// one quotient bit per cycle on the magnitude
	assign trial = {rem_q[WS_BITS-2:0], dvd_q[SEQ_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(SEQ_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= value[SEQ_BITS-1] ? SEQ_BITS'(-value) : SEQ_BITS'(value);
			neg_q <= value[SEQ_BITS-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= (trial >= div_q) ? trial - div_q : trial;
			dvd_q <= {dvd_q[SEQ_BITS-2:0], 1'b0};
		end
	end

	// negative operand: fold remainder back into 0..divisor-1
	assign fixed = (neg_q && rem_q != '0) ? div_q - rem_q : rem_q;
	assign slot  = SLOT_BITS'(fixed);
	assign done  = (cnt_q == '0);

endmodule

// ----- hdl/srws_ctrl.sv -----
module srws_ctrl import srws_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	output logic  result_valid,
	input  logic  result_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_n  = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_n   = S_MOD;
			end
			S_MOD: begin
				if (stat.mod_done) begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_n  = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

// ----- hdl/srws_dp.sv -----
module srws_dp import srws_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  item_t                   item,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SEQ_BITS-1:0]     cfg_data,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output result_t                 result
);

	typedef struct packed {
		logic [LEN_BITS-1:0]  len;
		logic [WORD_BITS-1:0] word;
	} slot_t;

	slot_t slot_mem [SLOTS];
	slot_t rd_q;

	item_t                it_q;
	result_t              result_q, res_n;
	logic [SEQ_BITS-1:0]  start_q, lower_q, current_q, tx_q;
	logic [WS_BITS-1:0]   ws_q, eff;
	logic                 done_q;
	logic [SEQ_BITS-1:0]  used_s1, dist_s1;
	logic [SEQ_BITS-1:0]  mod_src;
	logic [SLOT_BITS-1:0] idx;
	logic                 mod_done;

	logic [SEQ_BITS-1:0]  lower_n, current_n, tx_n, used_n;
	logic                 done_n, wr_en;

	always_comb begin
		if (ws_q == '0) begin
			eff = WS_BITS'(1);
		end else if (ws_q > WS_BITS'(SLOTS)) begin
			eff = WS_BITS'(SLOTS);
		end else begin
			eff = ws_q;
		end
	end

	always_comb begin
		unique case (it_q.mode)
			MODE_DATA: mod_src = current_q;
			MODE_SREJ: mod_src = it_q.seq_in;
			default:   mod_src = lower_q;
		endcase
	end

	srws_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start),
		.value   (mod_src),
		.divisor (eff),
		.done    (mod_done),
		.slot    (idx)
	);

	assign stat.mod_done = mod_done;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
		end
		if (cmd.start) begin
			used_s1 <= current_q - lower_q;
			dist_s1 <= it_q.seq_in - lower_q;
		end
		if (cmd.read) begin
			rd_q <= slot_mem[idx];
		end
		if (wr_en) begin
			slot_mem[idx] <= '{len: it_q.data_len, word: it_q.data_word};
		end
		if (cmd.commit) begin
			result_q <= res_n;
		end
	end

	always_comb begin
		res_n     = '0;
		lower_n   = lower_q;
		current_n = current_q;
		tx_n      = tx_q;
		done_n    = done_q;
		used_n    = used_s1;
		wr_en     = 1'b0;
		unique case (it_q.mode)
			MODE_DATA: begin
				done_n = done_q | it_q.file_done;
				if (used_s1 >= SEQ_BITS'(eff)) begin
					res_n.status = ST_FULL;
				end else begin
					wr_en              = cmd.commit;
					current_n          = current_q + SEQ_BITS'(1);
					used_n             = used_s1 + SEQ_BITS'(1);
					tx_n               = tx_q + SEQ_BITS'(1);
					res_n.send_valid   = 1'b1;
					res_n.send_kind    = KIND_DATA;
					res_n.send_seq     = tx_q;
					res_n.send_word    = it_q.data_word;
					res_n.send_len     = it_q.data_len;
					res_n.send_flag    = it_q.data_flag;
				end
			end
			MODE_ACK: begin
				if (!it_q.frame_ok || dist_s1[SEQ_BITS-1]) begin
					res_n.status = ST_IGNORED;
				end else if (dist_s1 > used_s1) begin
					res_n.status = ST_BEYOND;
				end else begin
					lower_n      = it_q.seq_in;
					used_n       = used_s1 - dist_s1;
					res_n.status = (done_q && it_q.seq_in == current_q) ? ST_ALL_ACKED : ST_OK;
				end
			end
			MODE_SREJ: begin
				if (!it_q.frame_ok || dist_s1 >= used_s1) begin
					res_n.status = ST_IGNORED;
				end else begin
					tx_n             = tx_q + SEQ_BITS'(1);
					res_n.send_valid = 1'b1;
					res_n.send_kind  = KIND_SREJ;
					res_n.send_seq   = it_q.seq_in;
					res_n.send_word  = rd_q.word;
					res_n.send_len   = rd_q.len;
				end
			end
			default: begin
				res_n.send_valid = 1'b1;
				res_n.send_kind  = (done_q && used_s1 == SEQ_BITS'(1)) ? KIND_EOF : KIND_TIMEOUT;
				res_n.send_seq   = lower_q;
				res_n.send_word  = rd_q.word;
				res_n.send_len   = rd_q.len;
			end
		endcase
		res_n.window_open = (used_n < SEQ_BITS'(eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			ws_q      <= WS_RESET;
			lower_q   <= '0;
			current_q <= '0;
			tx_q      <= '0;
			done_q    <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == REG_START_SEQ) begin
				start_q   <= cfg_data;
				lower_q   <= cfg_data;
				current_q <= cfg_data;
				tx_q      <= cfg_data;
				done_q    <= 1'b0;
			end else if (cfg_index == REG_WINDOW_SIZE) begin
				ws_q      <= cfg_data[WS_BITS-1:0];
				lower_q   <= start_q;
				current_q <= start_q;
				tx_q      <= start_q;
				done_q    <= 1'b0;
			end
		end else if (cmd.commit) begin
			lower_q   <= lower_n;
			current_q <= current_n;
			tx_q      <= tx_n;
			done_q    <= done_n;
		end
	end

	assign result = result_q;

endmodule

// ----- hdl/selective_reject_window_sender.sv -----
// Sender side of a selective-reject sliding window. Each item (send data, ACK,
// SREJ or timeout) yields exactly one result. An accepted item goes through setup,
// 32 steps of the bit-serial slot-index modulo unit (sequence number modulo the
// configured window size, clamped to 1..64), a wait for the modulo to finish,
// one slot memory read and a commit. The next item is taken the cycle after
// commit, so no new item enters while one is in flight. The block takes a new
// item while the previous result waits in the output register; a result still
// stalled when the next one is ready holds up that commit. Configuration writes
// are always accepted; a write to the start sequence or window size register
// restarts the window at the start sequence number; slot contents are kept.
// Write configuration only while no item is in flight. Slot memory has no reset:
// a timeout or SREJ on a slot never written returns undefined data.
module selective_reject_window_sender import srws_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  item_t                   item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output result_t                 result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SEQ_BITS-1:0]     cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	srws_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	srws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule
